FILE: rtl/perfect_number_check_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef PERFECT_NUMBER_CHECK_MACROS_SVH
`define PERFECT_NUMBER_CHECK_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define PNC_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("perfect_number_check: same-cycle check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define PNC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("perfect_number_check: next-cycle check failed");

`endif

FILE: rtl/pnc_pkg.sv
package pnc_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ACCUM,
    ST_FINISH
  } pnc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture the number, set the trial divisor to one, clear the sum.
    logic div_start;  // Begin a remainder computation for the current trial divisor.
    logic div_step;   // One restoring-division step.
    logic accum;      // Add the trial divisor if it divides, then advance it.
    logic emit;       // Drive the result registers and the done strobe.
  } pnc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trials_done;  // The trial divisor has passed half the number.
    logic div_last;     // The current division step is the last one.
  } pnc_status_t;

endpackage

FILE: rtl/pnc_ctrl.sv
module pnc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  pnc_pkg::pnc_status_t status_i,
  output pnc_pkg::pnc_cmd_t    cmd_o,
  output logic                 busy_o
);
  import pnc_pkg::*;

  pnc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.trials_done ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) state_d = ST_ACCUM;
      end
      ST_ACCUM:  state_d = ST_CHECK;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_CHECK:  cmd_o.div_start = !status_i.trials_done;
      ST_DIVIDE: cmd_o.div_step  = 1'b1;
      ST_ACCUM:  cmd_o.accum     = 1'b1;
      ST_FINISH: cmd_o.emit      = 1'b1;
      default:   busy_o          = 1'b0;
    endcase
  end

endmodule

FILE: rtl/pnc_dpath.sv
module pnc_dpath #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NUM_BITS-1:0]  number_i,
  input  pnc_pkg::pnc_cmd_t    cmd_i,
  output pnc_pkg::pnc_status_t status_o,
  output logic                 done_o,
  output logic                 is_perfect_o,
  output logic [NUM_BITS+1:0]  divisor_sum_o
);
  import pnc_pkg::*;

  localparam int unsigned SumW = NUM_BITS + 2;
  localparam int unsigned CntW = $clog2(NUM_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(NUM_BITS - 1);

  logic [NUM_BITS-1:0] num_q;      // number under test
  logic [NUM_BITS-1:0] trial_q;    // current trial divisor
  logic [SumW-1:0]     acc_q;      // running divisor sum
  logic [NUM_BITS-1:0] dvd_q;      // dividend shift register
  logic [NUM_BITS-1:0] rem_q;      // partial remainder
  logic [CntW-1:0]     cnt_q;      // division steps left after this one
  logic                done_q;
  logic                perfect_q;
  logic [SumW-1:0]     sum_out_q;

  logic [NUM_BITS:0]   rem_shift;
  logic                rem_ge;
  logic [NUM_BITS-1:0] rem_d;
  logic [SumW:0]       acc_sum;
  logic [SumW-1:0]     acc_d;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  assign rem_shift = {rem_q, dvd_q[NUM_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, trial_q};
  assign rem_d     = rem_ge ? NUM_BITS'(rem_shift - {1'b0, trial_q})
                            : rem_shift[NUM_BITS-1:0];

  // Saturating add of the trial divisor into the sum.
  assign acc_sum = {1'b0, acc_q} + (SumW + 1)'(trial_q);
  assign acc_d   = acc_sum[SumW] ? {SumW{1'b1}} : acc_sum[SumW-1:0];

  assign status_o.trials_done = trial_q > (num_q >> 1);
  assign status_o.div_last    = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q   <= number_i;
      trial_q <= NUM_BITS'(1);
      acc_q   <= '0;
    end
    if (cmd_i.div_start) begin
      dvd_q <= num_q;
      rem_q <= '0;
      cnt_q <= CntLast;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NUM_BITS-2:0], 1'b0};
      rem_q <= rem_d;
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cmd_i.accum) begin
      if (rem_q == '0) acc_q <= acc_d;
      trial_q <= trial_q + NUM_BITS'(1);
    end
    if (cmd_i.emit) begin
      sum_out_q <= acc_q;
      perfect_q <= (num_q != '0) && (acc_q == SumW'(num_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign done_o        = done_q;
  assign is_perfect_o  = perfect_q;
  assign divisor_sum_o = sum_out_q;

endmodule

FILE: rtl/perfect_number_check.sv
// Perfect number check. Raise start_i with a number on number_i while busy_o
// is low and the block takes that word at the clock edge. It then adds up every
// trial divisor from one to half the number that leaves no remainder, which is
// the sum of the number's proper divisors, and reports that sum on
// divisor_sum_o together with is_perfect_o, which is set when the sum equals
// the number. Zero and one both give a sum of zero and a clear flag. The sum
// saturates to all ones if it ever exceeds its NUM_BITS+2 bit field, which
// cannot happen at the default width. The result word is shown for exactly one
// cycle, marked by done_o; the receiver cannot stall it, so it must take the
// word in that cycle. The result registers hold their value afterwards, but
// only the cycle with done_o is the result. The block handles one number at a
// time: busy_o rises at the accepting edge and stays high until the cycle in
// which done_o rises, and a new word may be started in that same cycle. Each
// trial divisor passes through a check state, the bit-serial restoring
// remainder unit and an accumulate state; once the trial divisor passes half
// the number, a finish state drives the result registers and done_o.
module perfect_number_check #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] number_i,
  output logic                busy_o,
  output logic                done_o,
  output logic                is_perfect_o,
  output logic [NUM_BITS+1:0] divisor_sum_o
);
  import pnc_pkg::*;

  pnc_cmd_t    cmd;
  pnc_status_t status;

  // The controller sequences the trial divisors and the division steps.
  pnc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // The datapath holds the number, the trial divisor, the remainder unit and
  // the running sum, and registers the result word.
  pnc_dpath #(
    .NUM_BITS (NUM_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_i      (number_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .done_o        (done_o),
    .is_perfect_o  (is_perfect_o),
    .divisor_sum_o (divisor_sum_o)
  );

endmodule

FILE: rtl/pnc_checker.sv
`include "perfect_number_check_macros.svh"

module pnc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // An accepted word always starts a computation.
  `PNC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // The result strobe lasts a single cycle per word.
  `PNC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // A result is only shown once the block is free again.
  `PNC_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy_o)

  // Every computation ends with a result word.
  `PNC_ASSERT_SAME(a_end_result, clk_i, rst_ni, $fell(busy_o), done_o)

endmodule

bind perfect_number_check pnc_checker u_pnc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
